>>> rtl/link_reconnect_backoff_fsm_defines.svh
// Assertion macros for the RTL of the reconnect controller.
`ifndef LINK_RECONNECT_BACKOFF_FSM_DEFINES_SVH
`define LINK_RECONNECT_BACKOFF_FSM_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define LRB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lrb implication check failed");

// Next-cycle implication, sampled on aclk, off while in reset
`define LRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lrb next-cycle check failed");

`endif

>>> rtl/lrb_pkg.sv
package lrb_pkg;

    localparam int TimeW = 32;
    localparam int CntW  = 32;
    localparam int ModeW = 2;
    localparam int CfgIdxW = 2;

    // Link modes
    localparam logic [ModeW-1:0] MODE_IDLE       = 2'd0;
    localparam logic [ModeW-1:0] MODE_CONNECTING = 2'd1;
    localparam logic [ModeW-1:0] MODE_CONNECTED  = 2'd2;

    // Register indexes
    localparam logic [CfgIdxW-1:0] CFG_ENABLED    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_RETRY_BASE = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_RETRY_MAX  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_ATTEMPT_TO = 2'd3;

    // Register reset values
    localparam logic [TimeW-1:0] RETRY_BASE_RESET = 32'd1000;
    localparam logic [TimeW-1:0] RETRY_MAX_RESET  = 32'd60000;
    localparam logic [TimeW-1:0] ATTEMPT_TO_RESET = 32'(15 * 1000);

    typedef struct packed {
        logic             enabled;
        logic [TimeW-1:0] retry_base;
        logic [TimeW-1:0] retry_max;
        logic [TimeW-1:0] attempt_timeout;
    } lrb_cfg_t;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [TimeW-1:0] retry_delay;
        logic [TimeW-1:0] retry_mark;
        logic [TimeW-1:0] attempt_mark;
        logic             retry_pending;
        logic [CntW-1:0]  connects;
        logic [CntW-1:0]  drops;
    } lrb_state_t;

    typedef struct packed {
        logic             start_attempt;
        logic             drop_link;
    } lrb_cmd_t;

endpackage

>>> rtl/lrb_step.sv
module lrb_step
    import lrb_pkg::*;
(
    input  lrb_cfg_t         cfg,
    input  lrb_state_t       cur,
    input  logic [TimeW-1:0] now_ms,
    input  logic             link_up,
    output lrb_state_t       nxt,
    output lrb_cmd_t         cmd
);

    logic [TimeW-1:0] retry_age;
    logic [TimeW-1:0] attempt_age;
    logic             retry_due;
    logic             start;
    logic             attempt_expired;
    logic [TimeW-1:0] doubled_delay;

    // Elapsed tests on wrapping time marks
    assign retry_age = now_ms - cur.retry_mark;
    assign retry_due = !cur.retry_pending || (retry_age >= cur.retry_delay);
    assign start     = cfg.enabled && (cur.mode == MODE_IDLE) && !link_up && retry_due;

    // An attempt started this tick has age zero
    assign attempt_age     = start ? '0 : (now_ms - cur.attempt_mark);
    assign attempt_expired = attempt_age >= cfg.attempt_timeout;

    // Double the delay, capped at the maximum
    assign doubled_delay = (cur.retry_delay >= (cfg.retry_max >> 1)) ?
                           cfg.retry_max : {cur.retry_delay[TimeW-2:0], 1'b0};

    always_comb begin
        logic [ModeW-1:0] mid_mode;
        nxt = cur;
        cmd = '0;
        mid_mode = cur.mode;
        if (cfg.enabled) begin
            // Launch an attempt when idle, link down and retry due
            if (start) begin
                cmd.start_attempt = 1'b1;
                nxt.attempt_mark  = now_ms;
                nxt.retry_pending = 1'b0;
                mid_mode          = MODE_CONNECTING;
            end
            nxt.mode = mid_mode;
            case (mid_mode)
                MODE_IDLE: begin
                    if (link_up) begin
                        nxt.mode = MODE_CONNECTED;
                    end
                end
                MODE_CONNECTING: begin
                    if (link_up) begin
                        nxt.connects    = cur.connects + 1'b1;
                        nxt.retry_delay = cfg.retry_base;
                        nxt.mode        = MODE_CONNECTED;
                    end else if (attempt_expired) begin
                        cmd.drop_link     = 1'b1;
                        nxt.retry_mark    = now_ms;
                        nxt.retry_pending = 1'b1;
                        nxt.mode          = MODE_IDLE;
                        nxt.retry_delay   = doubled_delay;
                    end
                end
                MODE_CONNECTED: begin
                    if (!link_up) begin
                        nxt.drops         = cur.drops + 1'b1;
                        nxt.retry_mark    = now_ms;
                        nxt.retry_pending = 1'b1;
                        nxt.retry_delay   = cfg.retry_base;
                        nxt.mode          = MODE_IDLE;
                    end
                end
                default: begin
                    nxt.mode = MODE_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/link_reconnect_backoff_fsm.sv
// Link reconnect controller with capped exponential backoff.
//
// Input stream (s_axis_*): one word per tick, carrying the wrapping millisecond
// time and one sample of the radio association status. Result stream (m_axis_*):
// one word per tick with the start and drop commands, the mode after the tick,
// the current retry delay and the connect and drop counters.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write one register per cycle;
// write only while no tick is in flight.
//
// A tick is held in the input register; the mode update then loads the
// result register, which holds the result word until the receiver takes it.
// One tick is accepted per clock while the receiver does not stall; the rate
// is set by the state update loop through state_reg.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more tick; after that s_axis_tready drops.
// Reset (aresetn low, synchronous) empties both registers, returns the mode to
// idle with counters and marks at zero, and loads the register defaults.
module link_reconnect_backoff_fsm
    import lrb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [TimeW-1:0]    cfg_wdata,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [31:0] now_ms, [32] link_up, [39:33] zero
    input  logic [39:0]         s_axis_tdata,

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [0] start_attempt, [1] drop_link, [3:2] link_mode, [35:4] retry_delay_ms,
    // [67:36] connects_total, [99:68] drops_total, [103:100] zero
    output logic [103:0]        m_axis_tdata
);

`include "link_reconnect_backoff_fsm_defines.svh"

    lrb_cfg_t         cfg_reg;
    lrb_state_t       state_reg;
    lrb_state_t       state_next;
    lrb_cmd_t         cmd_next;

    logic             in_valid_reg;
    logic [TimeW-1:0] in_now_reg;
    logic             in_up_reg;

    logic             out_valid_reg;
    lrb_cmd_t         out_cmd_reg;
    lrb_state_t       out_state_reg;

    logic             advance;

    // Move the held tick into the result register when there is room
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enabled         <= 1'b0;
            cfg_reg.retry_base      <= RETRY_BASE_RESET;
            cfg_reg.retry_max       <= RETRY_MAX_RESET;
            cfg_reg.attempt_timeout <= ATTEMPT_TO_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ENABLED:    cfg_reg.enabled         <= cfg_wdata[0];
                CFG_RETRY_BASE: cfg_reg.retry_base      <= cfg_wdata;
                CFG_RETRY_MAX:  cfg_reg.retry_max       <= cfg_wdata;
                CFG_ATTEMPT_TO: cfg_reg.attempt_timeout <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_now_reg <= s_axis_tdata[TimeW-1:0];
            in_up_reg  <= s_axis_tdata[TimeW];
        end
    end

    lrb_step u_step (
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .now_ms  (in_now_reg),
        .link_up (in_up_reg),
        .nxt     (state_next),
        .cmd     (cmd_next)
    );

    // Controller state: advance once per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode          <= MODE_IDLE;
            state_reg.retry_delay   <= RETRY_BASE_RESET;
            state_reg.retry_mark    <= '0;
            state_reg.attempt_mark  <= '0;
            state_reg.retry_pending <= 1'b0;
            state_reg.connects      <= '0;
            state_reg.drops         <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_cmd_reg   <= cmd_next;
            out_state_reg <= state_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0,
                            out_state_reg.drops,
                            out_state_reg.connects,
                            out_state_reg.retry_delay,
                            out_state_reg.mode,
                            out_cmd_reg.drop_link,
                            out_cmd_reg.start_attempt};

    // A dropped attempt always leaves the controller idle
    `LRB_ASSERT_IMPL(a_drop_leaves_idle, out_valid_reg && out_cmd_reg.drop_link,
                     out_state_reg.mode == MODE_IDLE)
    // A started attempt never reports an established link
    `LRB_ASSERT_IMPL(a_start_not_connected, out_valid_reg && out_cmd_reg.start_attempt,
                     out_state_reg.mode == MODE_CONNECTING || out_state_reg.mode == MODE_IDLE)
    // A tick while disabled leaves the state unchanged
    `LRB_ASSERT_NEXT(a_disabled_holds, advance && !cfg_reg.enabled,
                     state_reg == $past(state_reg))

endmodule
